// File: design/apt_pkg.sv
// ----------------------------------------------------------------------------
// apt_pkg
// Shared widths, codes and the command record passed from the front end to
// the presence table engine.
// ----------------------------------------------------------------------------
package apt_pkg;

   // Default table size and field widths
   localparam int CAPACITY_DEF = 64;
   localparam int BADGE_W      = 64;

   // Action codes
   localparam logic [1:0] ACT_ENTRY = 2'd0;
   localparam logic [1:0] ACT_EXIT  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Reader direction codes
   localparam logic [1:0] DIR_IN    = 2'd0;
   localparam logic [1:0] DIR_OUT   = 2'd1;
   localparam logic [1:0] DIR_INOUT = 2'd2;

   // Result status codes
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_DIRECTION  = 2'd1;
   localparam logic [1:0] ST_NOT_INSIDE = 2'd2;
   localparam logic [1:0] ST_FULL       = 2'd3;

   // Engine operation codes; OP_DONE carries a finished result
   localparam logic [1:0] OP_DONE  = 2'd0;
   localparam logic [1:0] OP_ENTRY = 2'd1;
   localparam logic [1:0] OP_EXIT  = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef struct packed {
      logic [1:0]         op;
      logic               granted;
      logic [1:0]         status;
      logic [BADGE_W-1:0] badge;
   } cmd_type;

endpackage

// File: design/anti_passback_presence_table.sv
// ----------------------------------------------------------------------------
// anti_passback_presence_table
// Anti-passback presence table: tracks which badges are inside a zone and
// answers entry, exit and clear requests with a grant and a status.
// ----------------------------------------------------------------------------
// After reset the block clears every slot of its slot memory and holds
// req_ready low until that is done. For each entry, exit or clear request
// the engine then reads every slot once through the single read port of the
// slot memory, writes at most one slot and posts the result. Requests
// rejected for a wrong reader direction, and unused action codes, need no
// scan: the engine posts the result they carry. A two-entry command queue
// sits in front of the engine, so up to two requests are taken while a scan
// runs, and results come out in request order through a registered response
// beat.
// ----------------------------------------------------------------------------
module anti_passback_presence_table
   import apt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_action,
   input  logic [BADGE_W-1:0] req_badge,
   input  logic [1:0]         req_reader_direction,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_granted,
   output logic [1:0]         rsp_status
);

   logic    push;
   cmd_type push_cmd;
   logic    q_full;
   logic    q_pop;
   logic    q_valid;
   cmd_type q_cmd;
   logic    init_busy;
   logic    accept_en;

   assign accept_en = !q_full && !init_busy;

   // Front end: classify request beats
   apt_front u_front (
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_badge            (req_badge),
      .req_reader_direction (req_reader_direction),
      .accept_en            (accept_en),
      .push                 (push),
      .push_cmd             (push_cmd)
   );

   // Command queue
   apt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_cmd   (q_cmd)
   );

   // Table engine
   apt_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_cmd       (q_cmd),
      .q_pop       (q_pop),
      .init_busy   (init_busy),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_granted (rsp_granted),
      .rsp_status  (rsp_status)
   );

`ifndef SYNTHESIS
   // No request is taken while the slot memory is being cleared
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !req_ready)
      else $error("request taken during slot clearing");

   // The engine only pops a queue that holds a command
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty command queue");

   // A granted result always reports ok
   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_granted |-> rsp_status == ST_OK)
      else $error("granted result with error status");
`endif

endmodule

// File: design/apt_front.sv
// ----------------------------------------------------------------------------
// apt_front
// Accepts request beats, checks action against reader direction and turns
// each beat into an engine command.
// ----------------------------------------------------------------------------
module apt_front
   import apt_pkg::*;
(
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_action,
   input  logic [BADGE_W-1:0]  req_badge,
   input  logic [1:0]          req_reader_direction,
   input  logic                accept_en,
   output logic                push,
   output cmd_type             push_cmd
);

   // Take a beat whenever the queue has room and the table is ready
   assign req_ready = accept_en;
   assign push      = req_valid & accept_en;

   // Classify: table operations go to the engine, rejects carry their result
   always_comb begin
      push_cmd         = '0;
      push_cmd.badge   = req_badge;
      push_cmd.op      = OP_DONE;
      push_cmd.granted = 1'b0;
      push_cmd.status  = ST_OK;
      case (req_action)
         ACT_ENTRY: begin
            if (req_reader_direction == DIR_IN || req_reader_direction == DIR_INOUT) begin
               push_cmd.op = OP_ENTRY;
            end else begin
               push_cmd.status = ST_DIRECTION;
            end
         end
         ACT_EXIT: begin
            if (req_reader_direction == DIR_OUT || req_reader_direction == DIR_INOUT) begin
               push_cmd.op = OP_EXIT;
            end else begin
               push_cmd.status = ST_DIRECTION;
            end
         end
         ACT_CLEAR: begin
            push_cmd.op = OP_CLEAR;
         end
         default: begin
            push_cmd.op = OP_DONE;
         end
      endcase
   end

endmodule

// File: design/apt_queue.sv
// ----------------------------------------------------------------------------
// apt_queue
// Two-entry command queue between the front end and the table engine.
// ----------------------------------------------------------------------------
module apt_queue
   import apt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cmd_type head_cmd
);

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full       = (count_ff == 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_cmd   = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store command payload
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/apt_back.sv
// ----------------------------------------------------------------------------
// apt_back
// Table engine: clears the slot memory after reset, scans all slots per table
// command, then updates at most one slot and registers the result beat.
// ----------------------------------------------------------------------------
module apt_back
   import apt_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  cmd_type    q_cmd,
   output logic       q_pop,
   output logic       init_busy,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_granted,
   output logic [1:0] rsp_status
);

   localparam int             AW        = $clog2(CAPACITY);
   localparam logic [AW-1:0]  LAST_SLOT = AW'(CAPACITY - 1);

   localparam logic [1:0] S_INIT   = 2'd0;
   localparam logic [1:0] S_IDLE   = 2'd1;
   localparam logic [1:0] S_SCAN   = 2'd2;
   localparam logic [1:0] S_DECIDE = 2'd3;

   // Slot memory: top bit marks the slot occupied
   logic [BADGE_W:0] mem [CAPACITY];

   logic [1:0]         state_ff, state_in;
   logic [1:0]         op_ff, op_in;
   logic [BADGE_W-1:0] badge_ff, badge_in;
   logic [AW-1:0]      cnt_ff, cnt_in;
   logic               issue_done_ff, issue_done_in;
   logic               chk_vld_ff;
   logic               chk_last_ff;
   logic [AW-1:0]      chk_addr_ff;
   logic [BADGE_W:0]   rd_data_ff;
   logic               hit_found_ff, hit_found_in;
   logic [AW-1:0]      hit_idx_ff, hit_idx_in;
   logic               free_found_ff, free_found_in;
   logic [AW-1:0]      free_idx_ff, free_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;

   logic               rd_en;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic [BADGE_W:0]   wr_data;
   logic               out_free;

   assign init_busy   = (state_ff == S_INIT);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_granted = rsp_granted_ff;
   assign rsp_status  = rsp_status_ff;
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      badge_in       = badge_ff;
      cnt_in         = cnt_ff;
      issue_done_in  = issue_done_ff;
      hit_found_in   = hit_found_ff;
      hit_idx_in     = hit_idx_ff;
      free_found_in  = free_found_ff;
      free_idx_in    = free_idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_granted_in = rsp_granted_ff;
      rsp_status_in  = rsp_status_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = free_idx_ff;
      wr_data        = {1'b0, badge_ff};
      q_pop          = 1'b0;

      // Drop the result once taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // Compare stage: note first matching slot and first free slot
      if (chk_vld_ff) begin
         if (rd_data_ff[BADGE_W] && rd_data_ff[BADGE_W-1:0] == badge_ff && !hit_found_ff) begin
            hit_found_in = 1'b1;
            hit_idx_in   = chk_addr_ff;
         end
         if (!rd_data_ff[BADGE_W] && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = chk_addr_ff;
         end
      end

      case (state_ff)
         S_INIT: begin
            // Clear one slot per cycle
            wr_en   = 1'b1;
            wr_addr = cnt_ff;
            wr_data = '0;
            cnt_in  = cnt_ff + AW'(1);
            if (cnt_ff == LAST_SLOT) begin
               cnt_in   = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               if (q_cmd.op == OP_DONE) begin
                  if (out_free) begin
                     q_pop          = 1'b1;
                     rsp_valid_in   = 1'b1;
                     rsp_granted_in = q_cmd.granted;
                     rsp_status_in  = q_cmd.status;
                  end
               end else begin
                  q_pop         = 1'b1;
                  op_in         = q_cmd.op;
                  badge_in      = q_cmd.badge;
                  cnt_in        = '0;
                  issue_done_in = 1'b0;
                  hit_found_in  = 1'b0;
                  free_found_in = 1'b0;
                  state_in      = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // Issue one slot read per cycle
            if (!issue_done_ff) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + AW'(1);
               if (cnt_ff == LAST_SLOT) begin
                  cnt_in        = '0;
                  issue_done_in = 1'b1;
               end
            end
            if (chk_last_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            // Update the table and post the result
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_granted_in = 1'b0;
               rsp_status_in  = ST_OK;
               state_in       = S_IDLE;
               case (op_ff)
                  OP_ENTRY: begin
                     if (hit_found_ff) begin
                        rsp_granted_in = 1'b1;
                     end else if (free_found_ff) begin
                        wr_en          = 1'b1;
                        wr_addr        = free_idx_ff;
                        wr_data        = {1'b1, badge_ff};
                        rsp_granted_in = 1'b1;
                     end else begin
                        rsp_status_in = ST_FULL;
                     end
                  end
                  OP_EXIT: begin
                     if (hit_found_ff) begin
                        wr_en          = 1'b1;
                        wr_addr        = hit_idx_ff;
                        rsp_granted_in = 1'b1;
                     end else begin
                        rsp_status_in = ST_NOT_INSIDE;
                     end
                  end
                  default: begin
                     if (hit_found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = hit_idx_ff;
                     end
                     rsp_granted_in = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cnt_ff        <= '0;
         issue_done_ff <= 1'b0;
         chk_vld_ff    <= 1'b0;
         chk_last_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         issue_done_ff <= issue_done_in;
         chk_vld_ff    <= rd_en;
         chk_last_ff   <= rd_en && (cnt_ff == LAST_SLOT);
         rsp_valid_ff  <= rsp_valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      op_ff          <= op_in;
      badge_ff       <= badge_in;
      hit_idx_ff     <= hit_idx_in;
      free_idx_ff    <= free_idx_in;
      chk_addr_ff    <= cnt_ff;
      rsp_granted_ff <= rsp_granted_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // Slot memory: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[cnt_ff];
      end
   end

endmodule
